@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type             req_type;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               overflow;
      logic               div_by_zero;
   } rsp_item_type;

   // queue entry: the item plus its divide-by-zero class
   typedef struct packed {
      req_item_type req;
      logic         dz;
   } q_item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // quotient bits kept before saturation, remainder width, exact sum width
   localparam int QUO_W = 33;
   localparam int DIV_W = 98;
   localparam int VAL_W = 65;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             hi;
      logic             neg;
   } div_part_type;

   typedef struct packed {
      op_type       op;
      logic         dz;
      logic [63:0]  den;
      div_part_type re;
      div_part_type im;
   } div_stage_type;

endpackage

@@ hw/rtl/cau_front.sv @@
module cau_front import cau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   input  logic         pop,
   output logic         head_vld,
   output q_item_type   head
);

   q_item_type              fifo_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    push;
   q_item_type              item;

   // classify: divide with a zero second operand
   always_comb begin
      item.req = req_data;
      item.dz  = (req_data.req_type == OP_DIV) && (req_data.b_re == 32'sd0) &&
                 (req_data.b_im == 32'sd0);
   end

   assign req_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign head_vld  = (cnt_ff != '0);
   assign head      = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_vld)
      else $error("pop from empty queue");

   a_cnt_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

@@ hw/rtl/cau_div_step.sv @@
module cau_div_step import cau_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          vld_in,
   input  div_stage_type stage_in,
   output logic          vld_out,
   output div_stage_type stage_out
);

   logic          vld_ff;
   div_stage_type stage_ff, stage_nx;
   logic [DIV_W-1:0] dsh;
   logic [DIV_W:0]   diff_re, diff_im;

   // one restoring step per part: subtract den << BIT if it fits
   always_comb begin
      stage_nx = stage_in;
      dsh      = DIV_W'(stage_in.den) << BIT;
      diff_re  = {1'b0, stage_in.re.rem} - {1'b0, dsh};
      diff_im  = {1'b0, stage_in.im.rem} - {1'b0, dsh};
      if (stage_in.op == OP_DIV && !stage_in.dz) begin
         if (!diff_re[DIV_W]) begin
            stage_nx.re.rem      = diff_re[DIV_W-1:0];
            stage_nx.re.quo[BIT] = 1'b1;
         end
         if (!diff_im[DIV_W]) begin
            stage_nx.im.rem      = diff_im[DIV_W-1:0];
            stage_nx.im.quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_nx;
      end
   end

   assign vld_out   = vld_ff;
   assign stage_out = stage_ff;

endmodule

@@ hw/rtl/cau_back.sv @@
module cau_back import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_vld,
   input  q_item_type   head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   localparam logic signed [VAL_W-1:0] SAT_MAX = 65'sh0_7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] SAT_MIN = -65'sh0_8000_0000;

   logic adv;

   // stage 1: products, squares of b and plain sums
   logic               s1_vld_ff;
   op_type             s1_op_ff;
   logic               s1_dz_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [63:0] sq_r_in, sq_i_in;
   logic [63:0]        sq_r_ff, sq_i_ff;
   logic signed [32:0] sum_re_ff, sum_im_ff, sum_re_in, sum_im_in;

   // stage 2: exact part values and |b|^2
   logic                     s2_vld_ff;
   op_type                   s2_op_ff;
   logic                     s2_dz_ff;
   logic [63:0]              den_ff, den_in;
   logic signed [VAL_W-1:0]  v_re_ff, v_im_ff, v_re_in, v_im_in, m_re, m_im;

   // stage 3 onward: divider chain
   div_stage_type chain [QUO_W+1];
   logic [QUO_W:0] vld_chain;
   div_stage_type s3_in;
   logic          s3_vld_ff;
   div_stage_type s3_ff;

   // output register
   logic         out_vld_ff, out_vld_in;
   rsp_item_type out_ff, out_in;
   sat_type      sr, si;

   function automatic div_part_type prep(logic signed [VAL_W-1:0] v, logic [63:0] den,
                                         op_type op);
      div_part_type     p;
      logic [63:0]      mag;
      logic [DIV_W-1:0] num;
      p = '0;
      if (op == OP_DIV) begin
         p.neg = v[VAL_W-1];
         mag   = p.neg ? 64'(-v) : 64'(v);
         num   = DIV_W'(mag) << FRAC_BITS;
         p.hi  = num >= (DIV_W'(den) << QUO_W);
         p.rem = num;
      end else begin
         p.rem = DIV_W'(v);
      end
      return p;
   endfunction

   function automatic sat_type sat(div_part_type p, op_type op);
      sat_type                 s;
      logic signed [VAL_W-1:0] v;
      v = $signed(p.rem[VAL_W-1:0]);
      if (op == OP_DIV) begin
         if (!p.neg) begin
            s.ovf = p.hi || p.quo[QUO_W-1] || p.quo[QUO_W-2];
            s.val = s.ovf ? 32'h7FFF_FFFF : p.quo[31:0];
         end else begin
            s.ovf = p.hi || (p.quo > 33'h0_8000_0000);
            s.val = s.ovf ? 32'h8000_0000 : 32'(-p.quo);
         end
      end else begin
         if (v > SAT_MAX) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
         end else if (v < SAT_MIN) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
         end else begin
            s.ovf = 1'b0;
            s.val = v[31:0];
         end
      end
      return s;
   endfunction

   assign adv = !vld_chain[QUO_W] || !out_vld_ff || rsp_ready;
   assign pop = adv && head_vld;

   // stage 1
   always_comb begin
      p_rr_in = head.req.a_re * head.req.b_re;
      p_ii_in = head.req.a_im * head.req.b_im;
      p_ri_in = head.req.a_re * head.req.b_im;
      p_ir_in = head.req.a_im * head.req.b_re;
      sq_r_in = head.req.b_re * head.req.b_re;
      sq_i_in = head.req.b_im * head.req.b_im;
      case (head.req.req_type)
         OP_SUB: begin
            sum_re_in = 33'(head.req.a_re) - 33'(head.req.b_re);
            sum_im_in = 33'(head.req.a_im) - 33'(head.req.b_im);
         end
         default: begin
            sum_re_in = 33'(head.req.a_re) + 33'(head.req.b_re);
            sum_im_in = 33'(head.req.a_im) + 33'(head.req.b_im);
         end
      endcase
   end

   // stage 2
   always_comb begin
      m_re   = VAL_W'(p_rr_ff) - VAL_W'(p_ii_ff);
      m_im   = VAL_W'(p_ri_ff) + VAL_W'(p_ir_ff);
      den_in = sq_r_ff + sq_i_ff;
      case (s1_op_ff)
         OP_MUL: begin
            v_re_in = m_re >>> FRAC_BITS;
            v_im_in = m_im >>> FRAC_BITS;
         end
         OP_DIV: begin
            v_re_in = VAL_W'(p_rr_ff) + VAL_W'(p_ii_ff);
            v_im_in = VAL_W'(p_ir_ff) - VAL_W'(p_ri_ff);
         end
         default: begin
            v_re_in = VAL_W'(sum_re_ff);
            v_im_in = VAL_W'(sum_im_ff);
         end
      endcase
   end

   // stage 3: magnitudes, dividend alignment, quotient range check
   always_comb begin
      s3_in.op  = s2_op_ff;
      s3_in.dz  = s2_dz_ff;
      s3_in.den = den_ff;
      s3_in.re  = prep(v_re_ff, den_ff, s2_op_ff);
      s3_in.im  = prep(v_im_ff, den_ff, s2_op_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= head_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= head.req.req_type;
         s1_dz_ff  <= head.dz;
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         sq_r_ff   <= $unsigned(sq_r_in);
         sq_i_ff   <= $unsigned(sq_i_in);
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         s2_op_ff  <= s1_op_ff;
         s2_dz_ff  <= s1_dz_ff;
         den_ff    <= den_in;
         v_re_ff   <= v_re_in;
         v_im_ff   <= v_im_in;
         s3_ff     <= s3_in;
      end
   end

   assign vld_chain[0] = s3_vld_ff;
   assign chain[0]     = s3_ff;

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      cau_div_step #(
         .BIT(QUO_W - 1 - i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .vld_in    (vld_chain[i]),
         .stage_in  (chain[i]),
         .vld_out   (vld_chain[i+1]),
         .stage_out (chain[i+1])
      );
   end

   // saturation and flags into the output register
   always_comb begin
      sr                 = sat(chain[QUO_W].re, chain[QUO_W].op);
      si                 = sat(chain[QUO_W].im, chain[QUO_W].op);
      out_in.res_re      = sr.val;
      out_in.res_im      = si.val;
      out_in.overflow    = sr.ovf || si.ovf;
      out_in.div_by_zero = 1'b0;
      if (chain[QUO_W].dz) begin
         out_in.res_re      = '0;
         out_in.res_im      = '0;
         out_in.overflow    = 1'b0;
         out_in.div_by_zero = 1'b1;
      end
      out_vld_in = vld_chain[QUO_W] ? 1'b1 : (out_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_chain[QUO_W] && adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |->
         rsp_data.res_re == 32'sd0 && rsp_data.res_im == 32'sd0 && !rsp_data.overflow)
      else $error("divide by zero result not cleared");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vld_chain[QUO_W] && !adv |=> vld_chain[QUO_W] && $stable(chain[QUO_W]))
      else $error("last divider stage lost its item while stalled");

   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_vld_ff)
      else $error("popped item did not enter the pipeline");

endmodule

@@ hw/rtl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit on signed fixed point with FRAC_BITS fraction bits (Q16.16
// by default): add, subtract, multiply (four products, result floored) and divide
// (a * conj(b) / |b|^2, truncated toward zero), each part saturated to 32 bits with
// an overflow flag; a divide by b = 0 returns zero and raises div_by_zero. One item
// is accepted per cycle while req_ready is high, and results return in order. Items pass
// through one product stage, one sum stage, one alignment stage, 33 restoring
// divider stages (one quotient bit each) and the output register; all operations
// take the same path so order holds. A 4-entry queue sits in front of the datapath,
// so req_ready only drops once the output is stalled long enough to fill it.
module complex_arithmetic_unit_top import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   // queue between the front classifier and the arithmetic pipeline
   logic       head_vld;
   logic       pop;
   q_item_type head;

   // front: accept items, flag divide by zero, buffer
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pop       (pop),
      .head_vld  (head_vld),
      .head      (head)
   );

   // back: products, sums, divider chain, saturation, output register
   cau_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_vld  (head_vld),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
